FILE: src/ooi_pkg.sv
// Shared types, constants and helper functions for the out-of-order issue select block.
// Used by every module under src; depends on nothing.
`default_nettype none

package ooi_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PHYS_REGS   = 64;
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int SW          = QW + 1;
    localparam int MAX_RES     = 5;
    localparam int RW          = $clog2(MAX_RES + 1);

    localparam logic [2:0] CLS_INT    = 3'd0;
    localparam logic [2:0] CLS_BRANCH = 3'd1;
    localparam logic [2:0] CLS_FPADD  = 3'd2;
    localparam logic [2:0] CLS_FPMUL  = 3'd3;
    localparam logic [2:0] CLS_LOAD   = 3'd4;
    localparam logic [2:0] CLS_STORE  = 3'd5;

    localparam logic [7:0] MASK_INT    = 8'h01;
    localparam logic [7:0] MASK_BRANCH = 8'h02;
    localparam logic [7:0] MASK_INTQ   = 8'h03;
    localparam logic [7:0] MASK_FPADD  = 8'h04;
    localparam logic [7:0] MASK_FPMUL  = 8'h08;

    typedef struct packed {
        logic [2:0]  cls;
        logic [5:0]  src_a;
        logic [5:0]  src_b;
        logic [15:0] tag;
    } entry_t;

    typedef enum logic [2:0] {
        UNIT_ALU1  = 3'd0,
        UNIT_ALU2  = 3'd1,
        UNIT_ADDR  = 3'd2,
        UNIT_FPADD = 3'd3,
        UNIT_FPMUL = 3'd4
    } unit_t;

    typedef enum logic [1:0] {
        Q_NONE,
        Q_TAKE,
        Q_HEAD
    } qop_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_ALU1,
        S_ALU2,
        S_ADDR,
        S_FPADD,
        S_FPMUL,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  enq;
        logic  step;
        unit_t unit;
        logic  adv;
    } ctrl_cmd_t;

    function automatic logic reg_ready(logic [5:0] r, logic [63:0] busy);
        return ({1'b0, r} >= 7'(PHYS_REGS)) || !busy[r];
    endfunction

    function automatic logic entry_ready(entry_t e, logic [63:0] busy);
        return reg_ready(e.src_a, busy) && reg_ready(e.src_b, busy);
    endfunction

endpackage

`default_nettype wire

FILE: src/out_of_order_issue_select.sv
// Top level of the out-of-order issue select block: wakeup/select over three issue queues.
// Depends on ooi_pkg, ooi_ctrl, ooi_datapath (and through it ooi_queue).
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------------
//   input    | in_valid / in_stall  | cmd, instr_class, src_a, src_b, instr_tag,
//            |                      | alu1_full .. fp_mul_full, busy_mask
//   output   | out_valid / out_stall| issue_valid, issue_unit, issued_tag, issued_class,
//            |                      | last, queues_empty, can_accept, enqueue_dropped
//
// One item at a time. An enqueue goes through accept, queue write and one result.
// A tick walks the five units in order, one select-and-collapse of one queue per cycle,
// buffers results, then emits one output per result or one empty output (1 to 5 outputs).
// Reset clears the fill counts and the controller; queue entries are not cleared.
// While results are held under out_stall no new item is taken; payload stays stable.
`default_nettype none

module out_of_order_issue_select (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [2:0]  instr_class,
    input  wire logic [5:0]  src_a,
    input  wire logic [5:0]  src_b,
    input  wire logic [15:0] instr_tag,
    input  wire logic        alu1_full,
    input  wire logic        alu2_full,
    input  wire logic        addr_unit_full,
    input  wire logic        fp_adder_full,
    input  wire logic        fp_mul_full,
    input  wire logic [63:0] busy_mask,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             issue_valid,
    output logic [2:0]       issue_unit,
    output logic [15:0]      issued_tag,
    output logic [2:0]       issued_class,
    output logic             last,
    output logic             queues_empty,
    output logic             can_accept,
    output logic             enqueue_dropped
);

    ooi_pkg::ctrl_cmd_t ctl;
    logic               emit_last;

    // sequence the item: capture, then enqueue or the five unit steps, then drain
    ooi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .out_stall (out_stall),
        .emit_last (emit_last),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .ctl       (ctl)
    );

    // hold the queues and the result buffer
    ooi_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .instr_class     (instr_class),
        .src_a           (src_a),
        .src_b           (src_b),
        .instr_tag       (instr_tag),
        .alu1_full       (alu1_full),
        .alu2_full       (alu2_full),
        .addr_unit_full  (addr_unit_full),
        .fp_adder_full   (fp_adder_full),
        .fp_mul_full     (fp_mul_full),
        .busy_mask       (busy_mask),
        .emit_last       (emit_last),
        .issue_valid     (issue_valid),
        .issue_unit      (issue_unit),
        .issued_tag      (issued_tag),
        .issued_class    (issued_class),
        .queues_empty    (queues_empty),
        .can_accept      (can_accept),
        .enqueue_dropped (enqueue_dropped)
    );

    // mark the final result of the item
    assign last = emit_last;

endmodule

`default_nettype wire

FILE: src/ooi_queue.sv
// One collapsing issue queue: oldest-ready select, take with rotation, head rotation.
// Depends on ooi_pkg.
`default_nettype none

module ooi_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire ooi_pkg::entry_t    wr_entry,
    input  wire ooi_pkg::qop_t      op,
    input  wire logic [7:0]         mask_hi,
    input  wire logic [7:0]         mask_lo,
    input  wire logic [63:0]        busy,
    output logic                    issued,
    output ooi_pkg::entry_t         issued_entry,
    output logic [ooi_pkg::CW-1:0]  count,
    output logic                    full
);

    ooi_pkg::entry_t               mem [ooi_pkg::QUEUE_DEPTH];
    logic [ooi_pkg::CW-1:0]        count_reg;
    logic [ooi_pkg::QUEUE_DEPTH-1:0] hit_hi;
    logic [ooi_pkg::QUEUE_DEPTH-1:0] hit_lo;
    logic [ooi_pkg::QW-1:0]        k_hi;
    logic [ooi_pkg::QW-1:0]        k_lo;
    logic [ooi_pkg::QW-1:0]        k_sel;
    logic                          do_move;
    logic                          drop;
    logic [ooi_pkg::QW-1:0]        rot_idx [ooi_pkg::QUEUE_DEPTH];
    logic [ooi_pkg::SW-1:0]        sum;

    always_comb
    begin
        for (int i = 0; i < ooi_pkg::QUEUE_DEPTH; i++)
        begin
            hit_hi[i] = (ooi_pkg::CW'(i) < count_reg) && mask_hi[mem[i].cls]
                        && ooi_pkg::entry_ready(mem[i], busy);
            hit_lo[i] = (ooi_pkg::CW'(i) < count_reg) && mask_lo[mem[i].cls]
                        && ooi_pkg::entry_ready(mem[i], busy);
        end
        k_hi = '0;
        k_lo = '0;
        for (int i = ooi_pkg::QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (hit_hi[i])
            begin
                k_hi = ooi_pkg::QW'(i);
            end
            if (hit_lo[i])
            begin
                k_lo = ooi_pkg::QW'(i);
            end
        end

        do_move = 1'b0;
        drop    = 1'b0;
        k_sel   = '0;
        case (op)
            ooi_pkg::Q_TAKE:
            begin
                do_move = (|hit_hi) || (|hit_lo);
                drop    = do_move;
                k_sel   = (|hit_hi) ? k_hi : k_lo;
            end
            ooi_pkg::Q_HEAD:
            begin
                do_move = (count_reg != '0);
                drop    = do_move && ooi_pkg::entry_ready(mem[0], busy);
            end
            default:
            begin
                do_move = 1'b0;
            end
        endcase

        // entries after the pick come first, then those scanned before it
        for (int i = 0; i < ooi_pkg::QUEUE_DEPTH; i++)
        begin
            sum = ooi_pkg::SW'(i) + ooi_pkg::SW'(k_sel) + ooi_pkg::SW'(1);
            if (sum >= ooi_pkg::SW'(count_reg))
            begin
                sum = sum - ooi_pkg::SW'(count_reg);
            end
            rot_idx[i] = sum[ooi_pkg::QW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[ooi_pkg::QW-1:0]] <= wr_entry;
        end
        else if (do_move)
        begin
            for (int i = 0; i < ooi_pkg::QUEUE_DEPTH; i++)
            begin
                mem[i] <= mem[rot_idx[i]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (wr_en)
        begin
            count_reg <= count_reg + ooi_pkg::CW'(1);
        end
        else if (drop)
        begin
            count_reg <= count_reg - ooi_pkg::CW'(1);
        end
    end

    assign issued       = drop;
    assign issued_entry = mem[k_sel];
    assign count        = count_reg;
    assign full         = (count_reg == ooi_pkg::CW'(ooi_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: src/ooi_datapath.sv
// Datapath: captured item, three issue queues, result buffer and output fields.
// Depends on ooi_pkg and ooi_queue.
`default_nettype none

module ooi_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ooi_pkg::ctrl_cmd_t  ctl,
    input  wire logic [2:0]          instr_class,
    input  wire logic [5:0]          src_a,
    input  wire logic [5:0]          src_b,
    input  wire logic [15:0]         instr_tag,
    input  wire logic                alu1_full,
    input  wire logic                alu2_full,
    input  wire logic                addr_unit_full,
    input  wire logic                fp_adder_full,
    input  wire logic                fp_mul_full,
    input  wire logic [63:0]         busy_mask,
    output logic                     emit_last,
    output logic                     issue_valid,
    output logic [2:0]               issue_unit,
    output logic [15:0]              issued_tag,
    output logic [2:0]               issued_class,
    output logic                     queues_empty,
    output logic                     can_accept,
    output logic                     enqueue_dropped
);

    typedef struct packed {
        ooi_pkg::unit_t unit;
        logic [15:0]    tag;
        logic [2:0]     cls;
    } res_t;

    ooi_pkg::entry_t      ent_reg;
    logic [4:0]           full_reg;
    logic [63:0]          busy_reg;
    logic                 dropped_reg;
    logic [ooi_pkg::RW-1:0] nres_reg;
    logic [ooi_pkg::RW-1:0] optr_reg;
    res_t                 res_buf [ooi_pkg::MAX_RES];

    ooi_pkg::qop_t        int_op, fp_op, addr_op;
    logic [7:0]           int_hi, int_lo, fp_mask;
    logic                 int_wr, fp_wr, addr_wr;
    logic                 int_iss, fp_iss, addr_iss;
    ooi_pkg::entry_t      int_ent, fp_ent, addr_ent;
    logic [ooi_pkg::CW-1:0] int_cnt, fp_cnt, addr_cnt;
    logic                 int_full, fp_full, addr_full;
    logic                 enq_drop;
    logic                 hit;
    ooi_pkg::entry_t      hit_ent;
    res_t                 cur;

    always_comb
    begin
        int_op  = ooi_pkg::Q_NONE;
        fp_op   = ooi_pkg::Q_NONE;
        addr_op = ooi_pkg::Q_NONE;
        int_hi  = ooi_pkg::MASK_INTQ;
        int_lo  = ooi_pkg::MASK_INTQ;
        fp_mask = ooi_pkg::MASK_FPADD;
        hit     = 1'b0;
        hit_ent = int_ent;
        if (ctl.step)
        begin
            case (ctl.unit)
                ooi_pkg::UNIT_ALU1:
                begin
                    int_op  = full_reg[0] ? ooi_pkg::Q_NONE : ooi_pkg::Q_TAKE;
                    int_hi  = ooi_pkg::MASK_BRANCH;
                    int_lo  = ooi_pkg::MASK_INT;
                    hit     = int_iss;
                end
                ooi_pkg::UNIT_ALU2:
                begin
                    int_op  = full_reg[1] ? ooi_pkg::Q_NONE : ooi_pkg::Q_TAKE;
                    hit     = int_iss;
                end
                ooi_pkg::UNIT_ADDR:
                begin
                    addr_op = full_reg[2] ? ooi_pkg::Q_NONE : ooi_pkg::Q_HEAD;
                    hit     = addr_iss;
                    hit_ent = addr_ent;
                end
                ooi_pkg::UNIT_FPADD:
                begin
                    fp_op   = full_reg[3] ? ooi_pkg::Q_NONE : ooi_pkg::Q_TAKE;
                    hit     = fp_iss;
                    hit_ent = fp_ent;
                end
                ooi_pkg::UNIT_FPMUL:
                begin
                    fp_op   = full_reg[4] ? ooi_pkg::Q_NONE : ooi_pkg::Q_TAKE;
                    fp_mask = ooi_pkg::MASK_FPMUL;
                    hit     = fp_iss;
                    hit_ent = fp_ent;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end

        // route the enqueue by class; unknown classes store nothing
        int_wr   = 1'b0;
        fp_wr    = 1'b0;
        addr_wr  = 1'b0;
        enq_drop = 1'b0;
        if (ctl.enq)
        begin
            if (ent_reg.cls == ooi_pkg::CLS_INT || ent_reg.cls == ooi_pkg::CLS_BRANCH)
            begin
                int_wr   = !int_full;
                enq_drop = int_full;
            end
            else if (ent_reg.cls == ooi_pkg::CLS_FPADD || ent_reg.cls == ooi_pkg::CLS_FPMUL)
            begin
                fp_wr    = !fp_full;
                enq_drop = fp_full;
            end
            else if (ent_reg.cls == ooi_pkg::CLS_LOAD || ent_reg.cls == ooi_pkg::CLS_STORE)
            begin
                addr_wr  = !addr_full;
                enq_drop = addr_full;
            end
        end
    end

    ooi_queue u_int_q (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (int_wr),
        .wr_entry     (ent_reg),
        .op           (int_op),
        .mask_hi      (int_hi),
        .mask_lo      (int_lo),
        .busy         (busy_reg),
        .issued       (int_iss),
        .issued_entry (int_ent),
        .count        (int_cnt),
        .full         (int_full)
    );

    ooi_queue u_fp_q (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (fp_wr),
        .wr_entry     (ent_reg),
        .op           (fp_op),
        .mask_hi      (fp_mask),
        .mask_lo      (fp_mask),
        .busy         (busy_reg),
        .issued       (fp_iss),
        .issued_entry (fp_ent),
        .count        (fp_cnt),
        .full         (fp_full)
    );

    ooi_queue u_addr_q (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (addr_wr),
        .wr_entry     (ent_reg),
        .op           (addr_op),
        .mask_hi      (ooi_pkg::MASK_INTQ),
        .mask_lo      (ooi_pkg::MASK_INTQ),
        .busy         (busy_reg),
        .issued       (addr_iss),
        .issued_entry (addr_ent),
        .count        (addr_cnt),
        .full         (addr_full)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            ent_reg  <= '{cls: instr_class, src_a: src_a, src_b: src_b, tag: instr_tag};
            full_reg <= {fp_mul_full, fp_adder_full, addr_unit_full, alu2_full, alu1_full};
            busy_reg <= busy_mask;
        end
        if (ctl.step && hit)
        begin
            res_buf[nres_reg] <= '{unit: ctl.unit, tag: hit_ent.tag, cls: hit_ent.cls};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dropped_reg <= 1'b0;
            nres_reg    <= '0;
            optr_reg    <= '0;
        end
        else
        begin
            if (ctl.capture)
            begin
                dropped_reg <= 1'b0;
                nres_reg    <= '0;
                optr_reg    <= '0;
            end
            if (ctl.enq)
            begin
                dropped_reg <= enq_drop;
            end
            if (ctl.step && hit)
            begin
                nres_reg <= nres_reg + ooi_pkg::RW'(1);
            end
            // hold the pointer on the final result
            if (ctl.adv && !emit_last)
            begin
                optr_reg <= optr_reg + ooi_pkg::RW'(1);
            end
        end
    end

    assign cur             = res_buf[optr_reg];
    assign emit_last       = (nres_reg == '0) || (optr_reg + ooi_pkg::RW'(1) == nres_reg);
    assign issue_valid     = (nres_reg != '0);
    assign issue_unit      = issue_valid ? cur.unit : 3'd0;
    assign issued_tag      = issue_valid ? cur.tag : 16'd0;
    assign issued_class    = issue_valid ? cur.cls : 3'd0;
    assign queues_empty    = (int_cnt == '0) && (fp_cnt == '0) && (addr_cnt == '0);
    assign can_accept      = !int_full && !fp_full && !addr_full;
    assign enqueue_dropped = dropped_reg;

    a_nres_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= ooi_pkg::RW'(ooi_pkg::MAX_RES))
        else $error("result count beyond unit count");

    a_optr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (optr_reg < nres_reg) || (optr_reg == '0))
        else $error("read pointer past stored results");

    a_empty_accept: assert property (@(posedge clk) disable iff (!rst_n)
        queues_empty |-> can_accept)
        else $error("empty queues reported full");

    a_enq_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.enq |=> (nres_reg == '0))
        else $error("enqueue produced an issue");

endmodule

`default_nettype wire

FILE: src/ooi_ctrl.sv
// Controller state machine: accept, enqueue or per-unit issue steps, result drain.
// Depends on ooi_pkg.
`default_nettype none

module ooi_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        cmd,
    input  wire logic        out_stall,
    input  wire logic        emit_last,
    output logic             in_stall,
    output logic             out_valid,
    output ooi_pkg::ctrl_cmd_t ctl
);

    ooi_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ooi_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        ctl.capture = 1'b0;
        ctl.enq     = 1'b0;
        ctl.step    = 1'b0;
        ctl.unit    = ooi_pkg::UNIT_ALU1;
        ctl.adv     = 1'b0;
        case (state_reg)
            ooi_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = cmd ? ooi_pkg::S_ALU1 : ooi_pkg::S_ENQ;
                end
            end
            ooi_pkg::S_ENQ:
            begin
                ctl.enq    = 1'b1;
                state_next = ooi_pkg::S_EMIT;
            end
            ooi_pkg::S_ALU1:
            begin
                ctl.step   = 1'b1;
                ctl.unit   = ooi_pkg::UNIT_ALU1;
                state_next = ooi_pkg::S_ALU2;
            end
            ooi_pkg::S_ALU2:
            begin
                ctl.step   = 1'b1;
                ctl.unit   = ooi_pkg::UNIT_ALU2;
                state_next = ooi_pkg::S_ADDR;
            end
            ooi_pkg::S_ADDR:
            begin
                ctl.step   = 1'b1;
                ctl.unit   = ooi_pkg::UNIT_ADDR;
                state_next = ooi_pkg::S_FPADD;
            end
            ooi_pkg::S_FPADD:
            begin
                ctl.step   = 1'b1;
                ctl.unit   = ooi_pkg::UNIT_FPADD;
                state_next = ooi_pkg::S_FPMUL;
            end
            ooi_pkg::S_FPMUL:
            begin
                ctl.step   = 1'b1;
                ctl.unit   = ooi_pkg::UNIT_FPMUL;
                state_next = ooi_pkg::S_EMIT;
            end
            ooi_pkg::S_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    ctl.adv = 1'b1;
                    if (emit_last)
                    begin
                        state_next = ooi_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ooi_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
